// ===== rtl/assert_macros.svh =====
// Assertion macros for the contact polygon reduction RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_ALWAYS(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("assertion failed");
`else
`define ASSERT_ALWAYS(label, clk, rst_n, prop)
`define ASSERT_NEXT(label, clk, rst_n, pre, post)
`endif
`endif

// ===== rtl/cpr_pkg.sv =====
// Types, constants and codes for the contact polygon reduction block.
package cpr_pkg;

    localparam int MAX_POINTS = 32;
    localparam int MAX_KEPT   = 4;
    localparam int IDX_W      = $clog2(MAX_POINTS);
    localparam int CNT_W      = $clog2(MAX_POINTS + 1);
    localparam int KEPT_W     = $clog2(MAX_KEPT + 1);
    localparam int SLOT_W     = $clog2(MAX_KEPT);

    localparam int CRD_W   = 32;
    localparam int TAG_W   = 6;
    localparam int NRM_W   = 16;
    localparam int START_W = 5;
    localparam int CFG_W   = 16;
    localparam int CFG_IDX_W = 1;

    localparam int DIF_W  = CRD_W + 1;
    localparam int PRD_W  = 2 * DIF_W;
    localparam int CRS_W  = PRD_W + 1;
    localparam int NPR_W  = CRS_W + NRM_W;
    localparam int AREA_W = NPR_W + 3;
    localparam int DIST_W = PRD_W + 2;

    localparam int ENT_W      = 3 * CRD_W + TAG_W;
    localparam int NX_LO      = ENT_W;
    localparam int NY_LO      = NX_LO + NRM_W;
    localparam int NZ_LO      = NY_LO + NRM_W;
    localparam int START_LO   = NZ_LO + NRM_W;
    localparam int IN_BITS    = START_LO + START_W;
    localparam int IN_DATA_W  = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_DATA_W = ((ENT_W + 7) / 8) * 8;

    localparam logic [CFG_IDX_W-1:0] REG_AREA_TOL = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COINC    = 1'd1;
    localparam logic [CFG_W-1:0] AREA_TOL_RESET   = 16'd655;
    localparam logic [CFG_W-1:0] COINC_RESET      = 16'd0;

    localparam logic [1:0] KIND_A    = 2'd0;
    localparam logic [1:0] KIND_B    = 2'd1;
    localparam logic [1:0] KIND_EVAL = 2'd2;
    localparam logic [1:0] KIND_OUT  = 2'd3;

    localparam logic [1:0] MODE_NONE = 2'd0;
    localparam logic [1:0] MODE_DIST = 2'd1;
    localparam logic [1:0] MODE_ABS  = 2'd2;
    localparam logic [1:0] MODE_MIN  = 2'd3;

    localparam logic [3:0] WAIT_CYC = 4'd10;

    typedef struct packed {
        logic             wr_en;
        logic [IDX_W-1:0] wr_addr;
        logic             nrm_ld;
        logic             rd_en;
        logic [IDX_W-1:0] rd_addr;
        logic [1:0]       kind;
        logic             last;
        logic [1:0]       mode;
        logic             best_clr;
        logic             chosen_clr;
        logic             chosen_set;
        logic [IDX_W-1:0] chosen_idx;
    } cmd_t;

    typedef struct packed {
        logic [IDX_W-1:0] best_idx;
        logic             dist_below;
        logic             abs_below;
        logic             best_ccw;
        logic             last_ccw;
        logic             out_valid;
    } status_t;

endpackage

// ===== rtl/cpr_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module cpr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// ===== rtl/cpr_datapath.sv =====
// Point store, geometry pipeline, best-candidate tracking and output register.
module cpr_datapath (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic [cpr_pkg::IN_DATA_W-1:0]  s_tdata,
    input  logic                           cfg_wr_en,
    input  logic [cpr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [cpr_pkg::CFG_W-1:0]      cfg_data,
    output logic [cpr_pkg::OUT_DATA_W-1:0] m_tdata,
    output logic                           m_tlast,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    input  cpr_pkg::cmd_t                  cmd,
    output cpr_pkg::status_t               st
);

    localparam int CRD_W  = cpr_pkg::CRD_W;
    localparam int DIF_W  = cpr_pkg::DIF_W;
    localparam int PRD_W  = cpr_pkg::PRD_W;
    localparam int CRS_W  = cpr_pkg::CRS_W;
    localparam int NPR_W  = cpr_pkg::NPR_W;
    localparam int AREA_W = cpr_pkg::AREA_W;
    localparam int DIST_W = cpr_pkg::DIST_W;
    localparam int NRM_W  = cpr_pkg::NRM_W;
    localparam int IDX_W  = cpr_pkg::IDX_W;
    localparam int ENT_W  = cpr_pkg::ENT_W;

    logic [ENT_W-1:0] rd_data;

    cpr_ram #(
        .WIDTH(ENT_W),
        .DEPTH(cpr_pkg::MAX_POINTS)
    ) u_store (
        .clk(clk),
        .wr_en(cmd.wr_en),
        .wr_addr(cmd.wr_addr),
        .wr_data(s_tdata[ENT_W-1:0]),
        .rd_addr(cmd.rd_addr),
        .rd_data(rd_data)
    );

    logic signed [CRD_W-1:0] rx, ry, rz;
    assign rx = rd_data[CRD_W-1:0];
    assign ry = rd_data[2*CRD_W-1:CRD_W];
    assign rz = rd_data[3*CRD_W-1:2*CRD_W];

    logic [cpr_pkg::CFG_W-1:0] area_tol_reg, coinc_reg;
    logic signed [NRM_W-1:0]   nx_reg, ny_reg, nz_reg;
    logic [cpr_pkg::MAX_POINTS-1:0] chosen_reg, chosen_next;

    logic             s0_valid_reg, s0_last_reg;
    logic [1:0]       s0_kind_reg;
    logic [IDX_W-1:0] s0_idx_reg;

    logic signed [CRD_W-1:0] ax_reg, ay_reg, az_reg;
    logic signed [DIF_W-1:0] ux_reg, uy_reg, uz_reg;
    logic signed [DIF_W-1:0] vx_reg, vy_reg, vz_reg;
    logic signed [PRD_W-1:0] prd_reg [9];
    logic signed [CRS_W-1:0] cx_reg, cy_reg, cz_reg;
    logic signed [NPR_W-1:0] np_reg [3];
    logic signed [AREA_W-1:0] area5_reg, area6_reg, abs6_reg;
    logic [DIST_W-1:0] dist3_reg, dist4_reg, dist5_reg, dist6_reg;

    logic [6:1] v_reg;
    logic [IDX_W-1:0] idx1_reg, idx2_reg, idx3_reg, idx4_reg, idx5_reg, idx6_reg;

    logic signed [AREA_W-1:0] best_key_reg, best_area_reg, best_abs_reg;
    logic [IDX_W-1:0]         best_idx_reg;
    logic                     have_reg, last_ccw_reg;

    logic [ENT_W-1:0] out_data_reg;
    logic             out_last_reg, out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            area_tol_reg <= cpr_pkg::AREA_TOL_RESET;
            coinc_reg    <= cpr_pkg::COINC_RESET;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                cpr_pkg::REG_AREA_TOL: area_tol_reg <= cfg_data;
                cpr_pkg::REG_COINC:    coinc_reg    <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nx_reg <= '0;
            ny_reg <= '0;
            nz_reg <= '0;
        end
        else if (cmd.nrm_ld)
        begin
            nx_reg <= s_tdata[cpr_pkg::NX_LO +: NRM_W];
            ny_reg <= s_tdata[cpr_pkg::NY_LO +: NRM_W];
            nz_reg <= s_tdata[cpr_pkg::NZ_LO +: NRM_W];
        end
    end

    always_comb
    begin
        chosen_next = cmd.chosen_clr ? '0 : chosen_reg;
        if (cmd.chosen_set)
        begin
            chosen_next[cmd.chosen_idx] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chosen_reg <= '0;
        end
        else
        begin
            chosen_reg <= chosen_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
            v_reg        <= '0;
        end
        else
        begin
            s0_valid_reg <= cmd.rd_en;
            v_reg        <= {v_reg[5:1], s0_valid_reg && (s0_kind_reg == cpr_pkg::KIND_EVAL)};
        end
    end

    always_ff @(posedge clk)
    begin
        s0_kind_reg <= cmd.kind;
        s0_last_reg <= cmd.last;
        s0_idx_reg  <= cmd.rd_addr;
        if (s0_valid_reg && (s0_kind_reg == cpr_pkg::KIND_A))
        begin
            ax_reg <= rx;
            ay_reg <= ry;
            az_reg <= rz;
        end
        if (s0_valid_reg && (s0_kind_reg == cpr_pkg::KIND_B))
        begin
            ux_reg <= DIF_W'(rx) - DIF_W'(ax_reg);
            uy_reg <= DIF_W'(ry) - DIF_W'(ay_reg);
            uz_reg <= DIF_W'(rz) - DIF_W'(az_reg);
        end
        vx_reg   <= DIF_W'(rx) - DIF_W'(ax_reg);
        vy_reg   <= DIF_W'(ry) - DIF_W'(ay_reg);
        vz_reg   <= DIF_W'(rz) - DIF_W'(az_reg);
        idx1_reg <= s0_idx_reg;

        prd_reg[0] <= PRD_W'(uy_reg) * PRD_W'(vz_reg);
        prd_reg[1] <= PRD_W'(uz_reg) * PRD_W'(vy_reg);
        prd_reg[2] <= PRD_W'(uz_reg) * PRD_W'(vx_reg);
        prd_reg[3] <= PRD_W'(ux_reg) * PRD_W'(vz_reg);
        prd_reg[4] <= PRD_W'(ux_reg) * PRD_W'(vy_reg);
        prd_reg[5] <= PRD_W'(uy_reg) * PRD_W'(vx_reg);
        prd_reg[6] <= PRD_W'(vx_reg) * PRD_W'(vx_reg);
        prd_reg[7] <= PRD_W'(vy_reg) * PRD_W'(vy_reg);
        prd_reg[8] <= PRD_W'(vz_reg) * PRD_W'(vz_reg);
        idx2_reg   <= idx1_reg;

        cx_reg    <= CRS_W'(prd_reg[0]) - CRS_W'(prd_reg[1]);
        cy_reg    <= CRS_W'(prd_reg[2]) - CRS_W'(prd_reg[3]);
        cz_reg    <= CRS_W'(prd_reg[4]) - CRS_W'(prd_reg[5]);
        dist3_reg <= DIST_W'(prd_reg[6]) + DIST_W'(prd_reg[7]) + DIST_W'(prd_reg[8]);
        idx3_reg  <= idx2_reg;

        np_reg[0] <= NPR_W'(cx_reg) * NPR_W'(nx_reg);
        np_reg[1] <= NPR_W'(cy_reg) * NPR_W'(ny_reg);
        np_reg[2] <= NPR_W'(cz_reg) * NPR_W'(nz_reg);
        dist4_reg <= dist3_reg;
        idx4_reg  <= idx3_reg;

        area5_reg <= AREA_W'(np_reg[0]) + AREA_W'(np_reg[1]) + AREA_W'(np_reg[2]);
        dist5_reg <= dist4_reg;
        idx5_reg  <= idx4_reg;

        area6_reg <= area5_reg;
        abs6_reg  <= area5_reg[AREA_W-1] ? -area5_reg : area5_reg;
        dist6_reg <= dist5_reg;
        idx6_reg  <= idx5_reg;
    end

    logic signed [AREA_W-1:0] key6;
    logic                     better;

    always_comb
    begin
        case (cmd.mode)
            cpr_pkg::MODE_DIST: key6 = AREA_W'(dist6_reg);
            cpr_pkg::MODE_ABS:  key6 = abs6_reg;
            default:            key6 = area6_reg;
        endcase
        if (cmd.mode == cpr_pkg::MODE_MIN)
        begin
            better = !have_reg || (key6 < best_key_reg);
        end
        else
        begin
            better = !have_reg || (key6 > best_key_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            have_reg     <= 1'b0;
            last_ccw_reg <= 1'b0;
        end
        else
        begin
            if (v_reg[6])
            begin
                last_ccw_reg <= area6_reg > 0;
            end
            if (cmd.best_clr)
            begin
                have_reg <= 1'b0;
            end
            else if (v_reg[6] && (cmd.mode != cpr_pkg::MODE_NONE) &&
                     !chosen_reg[idx6_reg] && better)
            begin
                have_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (v_reg[6] && (cmd.mode != cpr_pkg::MODE_NONE) && !chosen_reg[idx6_reg] && better)
        begin
            best_key_reg  <= key6;
            best_area_reg <= area6_reg;
            best_abs_reg  <= abs6_reg;
            best_idx_reg  <= idx6_reg;
        end
    end

    logic signed [AREA_W-1:0] coinc_bound, tol2;
    assign coinc_bound = AREA_W'({coinc_reg, 16'b0});
    assign tol2        = AREA_W'({area_tol_reg, 31'b0});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s0_valid_reg && (s0_kind_reg == cpr_pkg::KIND_OUT))
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s0_valid_reg && (s0_kind_reg == cpr_pkg::KIND_OUT))
        begin
            out_data_reg <= rd_data;
            out_last_reg <= s0_last_reg;
        end
    end

    assign m_tdata  = cpr_pkg::OUT_DATA_W'(out_data_reg);
    assign m_tlast  = out_last_reg;
    assign m_tvalid = out_valid_reg;

    assign st.best_idx   = best_idx_reg;
    assign st.dist_below = best_key_reg < coinc_bound;
    assign st.abs_below  = best_abs_reg < tol2;
    assign st.best_ccw   = best_area_reg > 0;
    assign st.last_ccw   = last_ccw_reg;
    assign st.out_valid  = out_valid_reg;

endmodule

// ===== rtl/cpr_ctrl.sv =====
// Sequencer for loading, the three selection scans, the swap sort and output.
`include "assert_macros.svh"
module cpr_ctrl (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic                        s_tlast,
    input  logic [cpr_pkg::START_W-1:0] start_index,
    input  logic                        m_tready,
    output cpr_pkg::cmd_t               cmd,
    input  cpr_pkg::status_t            st
);

    localparam int IDX_W  = cpr_pkg::IDX_W;
    localparam int CNT_W  = cpr_pkg::CNT_W;
    localparam int KEPT_W = cpr_pkg::KEPT_W;
    localparam int SLOT_W = cpr_pkg::SLOT_W;
    localparam int START_W_L = cpr_pkg::START_W;

    localparam logic [3:0] ST_LOAD     = 4'd0;
    localparam logic [3:0] ST_SETUP    = 4'd1;
    localparam logic [3:0] ST_LDA      = 4'd2;
    localparam logic [3:0] ST_LDB      = 4'd3;
    localparam logic [3:0] ST_SCAN     = 4'd4;
    localparam logic [3:0] ST_EVAL     = 4'd5;
    localparam logic [3:0] ST_WAIT     = 4'd6;
    localparam logic [3:0] ST_DECIDE   = 4'd7;
    localparam logic [3:0] ST_PASS     = 4'd8;
    localparam logic [3:0] ST_OUT_RD   = 4'd9;
    localparam logic [3:0] ST_OUT_GAP  = 4'd10;
    localparam logic [3:0] ST_OUT_HOLD = 4'd11;

    localparam logic [1:0] PH_DIST = 2'd0;
    localparam logic [1:0] PH_AREA = 2'd1;
    localparam logic [1:0] PH_MIN  = 2'd2;
    localparam logic [1:0] PH_SORT = 2'd3;

    logic [3:0]         state_reg, state_next;
    logic [1:0]         phase_reg, phase_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [CNT_W-1:0]   n_reg, n_next;
    logic [START_W_L-1:0] start_reg, start_next;
    logic [KEPT_W-1:0]  nk_reg, nk_next;
    logic [IDX_W-1:0]   pk_reg [cpr_pkg::MAX_KEPT];
    logic [IDX_W-1:0]   pk_next [cpr_pkg::MAX_KEPT];
    logic [KEPT_W-1:0]  si_reg, si_next, sj_reg, sj_next;
    logic [SLOT_W-1:0]  ok_reg, ok_next;
    logic [IDX_W-1:0]   scan_reg, scan_next;
    logic [3:0]         wait_reg, wait_next;

    logic             accept;
    logic             out_is_last;
    logic [IDX_W-1:0] start_slot;

    assign accept      = s_tvalid && s_tready;
    assign s_tready    = (state_reg == ST_LOAD);
    assign out_is_last = (KEPT_W'(ok_reg) == nk_reg - KEPT_W'(1));
    assign start_slot  = (CNT_W'(start_reg) >= n_reg) ? '0 : IDX_W'(start_reg);

    always_comb
    begin
        state_next = state_reg;
        phase_next = phase_reg;
        cnt_next   = cnt_reg;
        n_next     = n_reg;
        start_next = start_reg;
        nk_next    = nk_reg;
        pk_next    = pk_reg;
        si_next    = si_reg;
        sj_next    = sj_reg;
        ok_next    = ok_reg;
        scan_next  = scan_reg;
        wait_next  = wait_reg;

        cmd            = '0;
        cmd.wr_addr    = cnt_reg[IDX_W-1:0];
        cmd.rd_addr    = pk_reg[0];
        cmd.chosen_idx = st.best_idx;
        unique case (phase_reg)
            PH_DIST: cmd.mode = cpr_pkg::MODE_DIST;
            PH_AREA: cmd.mode = cpr_pkg::MODE_ABS;
            PH_MIN:  cmd.mode = cpr_pkg::MODE_MIN;
            default: cmd.mode = cpr_pkg::MODE_NONE;
        endcase

        unique case (state_reg)
            ST_LOAD:
            begin
                if (accept)
                begin
                    cmd.wr_en = (cnt_reg < CNT_W'(cpr_pkg::MAX_POINTS));
                    cnt_next  = cnt_reg + CNT_W'(cmd.wr_en);
                    if (s_tlast)
                    begin
                        cmd.nrm_ld = 1'b1;
                        n_next     = cnt_next;
                        start_next = start_index;
                        cnt_next   = '0;
                        state_next = ST_SETUP;
                    end
                end
            end
            ST_SETUP:
            begin
                if (n_reg <= CNT_W'(cpr_pkg::MAX_KEPT))
                begin
                    for (int i = 0; i < cpr_pkg::MAX_KEPT; i++)
                    begin
                        pk_next[i] = IDX_W'(i);
                    end
                    nk_next    = KEPT_W'(n_reg);
                    si_next    = KEPT_W'(1);
                    phase_next = PH_SORT;
                    state_next = ST_PASS;
                end
                else
                begin
                    pk_next[0]     = start_slot;
                    cmd.chosen_clr = 1'b1;
                    cmd.chosen_set = 1'b1;
                    cmd.chosen_idx = start_slot;
                    phase_next     = PH_DIST;
                    state_next     = ST_LDA;
                end
            end
            ST_LDA:
            begin
                cmd.rd_en    = 1'b1;
                cmd.kind     = cpr_pkg::KIND_A;
                cmd.rd_addr  = pk_reg[0];
                cmd.best_clr = 1'b1;
                state_next   = ST_LDB;
            end
            ST_LDB:
            begin
                cmd.rd_en = 1'b1;
                cmd.kind  = cpr_pkg::KIND_B;
                unique case (phase_reg)
                    PH_DIST: cmd.rd_addr = pk_reg[0];
                    PH_SORT: cmd.rd_addr = pk_reg[si_reg[SLOT_W-1:0]];
                    default: cmd.rd_addr = pk_reg[1];
                endcase
                scan_next  = '0;
                state_next = (phase_reg == PH_SORT) ? ST_EVAL : ST_SCAN;
            end
            ST_SCAN:
            begin
                cmd.rd_en   = 1'b1;
                cmd.kind    = cpr_pkg::KIND_EVAL;
                cmd.rd_addr = scan_reg;
                if (CNT_W'(scan_reg) == n_reg - CNT_W'(1))
                begin
                    wait_next  = cpr_pkg::WAIT_CYC;
                    state_next = ST_WAIT;
                end
                else
                begin
                    scan_next = scan_reg + IDX_W'(1);
                end
            end
            ST_EVAL:
            begin
                cmd.rd_en   = 1'b1;
                cmd.kind    = cpr_pkg::KIND_EVAL;
                cmd.rd_addr = pk_reg[sj_reg[SLOT_W-1:0]];
                wait_next   = cpr_pkg::WAIT_CYC;
                state_next  = ST_WAIT;
            end
            ST_WAIT:
            begin
                wait_next = wait_reg - 4'd1;
                if (wait_reg == 4'd0)
                begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                unique case (phase_reg)
                    PH_DIST:
                    begin
                        if (st.dist_below)
                        begin
                            nk_next    = KEPT_W'(1);
                            ok_next    = '0;
                            state_next = ST_OUT_RD;
                        end
                        else
                        begin
                            pk_next[1]     = st.best_idx;
                            cmd.chosen_set = 1'b1;
                            phase_next     = PH_AREA;
                            state_next     = ST_LDA;
                        end
                    end
                    PH_AREA:
                    begin
                        if (st.abs_below)
                        begin
                            nk_next    = KEPT_W'(2);
                            ok_next    = '0;
                            state_next = ST_OUT_RD;
                        end
                        else
                        begin
                            if (!st.best_ccw)
                            begin
                                pk_next[0] = pk_reg[1];
                                pk_next[1] = pk_reg[0];
                            end
                            pk_next[2]     = st.best_idx;
                            cmd.chosen_set = 1'b1;
                            phase_next     = PH_MIN;
                            state_next     = ST_LDA;
                        end
                    end
                    PH_MIN:
                    begin
                        if (st.abs_below)
                        begin
                            nk_next    = KEPT_W'(3);
                            ok_next    = '0;
                            state_next = ST_OUT_RD;
                        end
                        else
                        begin
                            pk_next[3]     = st.best_idx;
                            cmd.chosen_set = 1'b1;
                            nk_next        = KEPT_W'(4);
                            si_next        = KEPT_W'(1);
                            phase_next     = PH_SORT;
                            state_next     = ST_PASS;
                        end
                    end
                    default:
                    begin
                        if (!st.last_ccw)
                        begin
                            pk_next[si_reg[SLOT_W-1:0]] = pk_reg[sj_reg[SLOT_W-1:0]];
                            pk_next[sj_reg[SLOT_W-1:0]] = pk_reg[si_reg[SLOT_W-1:0]];
                        end
                        if (sj_reg + KEPT_W'(1) < nk_reg)
                        begin
                            sj_next    = sj_reg + KEPT_W'(1);
                            state_next = ST_EVAL;
                        end
                        else
                        begin
                            si_next    = si_reg + KEPT_W'(1);
                            state_next = ST_PASS;
                        end
                    end
                endcase
            end
            ST_PASS:
            begin
                if (si_reg + KEPT_W'(1) >= nk_reg)
                begin
                    ok_next    = '0;
                    state_next = ST_OUT_RD;
                end
                else
                begin
                    sj_next    = si_reg + KEPT_W'(1);
                    state_next = ST_LDA;
                end
            end
            ST_OUT_RD:
            begin
                cmd.rd_en   = 1'b1;
                cmd.kind    = cpr_pkg::KIND_OUT;
                cmd.rd_addr = pk_reg[ok_reg];
                cmd.last    = out_is_last;
                state_next  = ST_OUT_GAP;
            end
            ST_OUT_GAP:
            begin
                state_next = ST_OUT_HOLD;
            end
            ST_OUT_HOLD:
            begin
                if (st.out_valid && m_tready)
                begin
                    if (out_is_last)
                    begin
                        state_next = ST_LOAD;
                    end
                    else
                    begin
                        ok_next    = ok_reg + SLOT_W'(1);
                        state_next = ST_OUT_RD;
                    end
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
            phase_reg <= PH_DIST;
            cnt_reg   <= '0;
            n_reg     <= '0;
            start_reg <= '0;
            nk_reg    <= '0;
            si_reg    <= '0;
            sj_reg    <= '0;
            ok_reg    <= '0;
            scan_reg  <= '0;
            wait_reg  <= '0;
            for (int i = 0; i < cpr_pkg::MAX_KEPT; i++)
            begin
                pk_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
            n_reg     <= n_next;
            start_reg <= start_next;
            nk_reg    <= nk_next;
            si_reg    <= si_next;
            sj_reg    <= sj_next;
            ok_reg    <= ok_next;
            scan_reg  <= scan_next;
            wait_reg  <= wait_next;
            pk_reg    <= pk_next;
        end
    end

    `ASSERT_ALWAYS(a_kept_max, clk, rst_n, nk_reg <= KEPT_W'(cpr_pkg::MAX_KEPT))
    `ASSERT_ALWAYS(a_out_in_hold, clk, rst_n, !st.out_valid || state_reg == ST_OUT_HOLD)
    `ASSERT_NEXT(a_last_clears, clk, rst_n, accept && s_tlast, cnt_reg == '0 && state_reg == ST_SETUP)

endmodule

// ===== rtl/contact_polygon_reduction.sv =====
// Contact polygon reduction: points are streamed in at one per cycle, and the
// request carrying tlast closes the set and starts the reduction, during which
// no input is taken. A set of five or more points runs up to three scans
// through one shared seven-stage geometry pipeline behind a single-read-port
// point store, each scan reading all n points and then waiting for the last
// result, then up to three swap tests, each sort pass opened by reloading its
// two reference points; a set of four or fewer goes straight to at most three
// swap tests. Each kept point is then read from the store, registered in the
// output register and held until m_tready takes it.
module contact_polygon_reduction (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // pos_x, pos_y, pos_z, point_tag, normal_x, normal_y, normal_z, start_index
    input  logic [cpr_pkg::IN_DATA_W-1:0]  s_tdata,
    input  logic                           s_tlast,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // out_x, out_y, out_z, out_tag
    output logic [cpr_pkg::OUT_DATA_W-1:0] m_tdata,
    output logic                           m_tlast,
    input  logic                           cfg_wr_en,
    input  logic [cpr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [cpr_pkg::CFG_W-1:0]      cfg_data
);

    cpr_pkg::cmd_t    cmd;
    cpr_pkg::status_t st;

    cpr_ctrl u_ctrl (
        .clk(clk),
        .rst_n(rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tlast(s_tlast),
        .start_index(s_tdata[cpr_pkg::START_LO +: cpr_pkg::START_W]),
        .m_tready(m_tready),
        .cmd(cmd),
        .st(st)
    );

    cpr_datapath u_datapath (
        .clk(clk),
        .rst_n(rst_n),
        .s_tdata(s_tdata),
        .cfg_wr_en(cfg_wr_en),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .m_tdata(m_tdata),
        .m_tlast(m_tlast),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .cmd(cmd),
        .st(st)
    );

endmodule
